### src/assert_macros.svh
// Assertion helpers for the RTL modules; the sequencer uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### src/adrf_pkg.sv
`default_nettype none

package adrf_pkg;

    localparam int RING_ENTRIES_DEF  = 32;
    localparam int CHUNK_SAMPLES_DEF = 4094;

    localparam int ADDR_W  = 32;
    localparam int POS_W   = 33;
    localparam int SLOT_W  = 5;
    localparam int COUNT_W = 12;
    localparam int KIND_W  = 3;

    localparam int WRAP_DEPTH = 64;

    typedef enum logic [KIND_W-1:0] {
        EV_DESC       = 3'd0,
        EV_NO_DATA    = 3'd1,
        EV_LAST_VALID = 3'd2,
        EV_SPURIOUS   = 3'd3,
        EV_FIFO_ERR   = 3'd4,
        EV_ADDR_ERR   = 3'd5,
        EV_STOPPED    = 3'd6
    } event_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_COUNT,
        ST_EMIT,
        ST_REPLY
    } seq_state_t;

    typedef struct packed {
        event_kind_t          kind;
        logic [SLOT_W-1:0]    slot;
        logic [ADDR_W-1:0]    addr;
        logic [COUNT_W-1:0]   count;
        logic [SLOT_W-1:0]    vi;
        logic                 last;
    } result_t;

    typedef logic [SLOT_W-1:0] wrap_tab_t [WRAP_DEPTH];

    // Slot after wrapping modulo the ring size, kept to the slot width
    function automatic wrap_tab_t build_wrap(input int ring);
        wrap_tab_t t;
        int        c;
        c = 0;
        for (int i = 0; i < WRAP_DEPTH; i++)
        begin
            t[i] = SLOT_W'(c);
            if (c == ring - 1)
                c = 0;
            else
                c = c + 1;
        end
        return t;
    endfunction

endpackage

`default_nettype wire

### src/adrf_chunk_unit.sv
`default_nettype none

module adrf_chunk_unit
    import adrf_pkg::*;
#(
    parameter int CHUNK_SAMPLES = CHUNK_SAMPLES_DEF
)
(
    input  wire logic [POS_W-1:0]                       pos,
    input  wire logic [ADDR_W-1:0]                      data_end,
    output logic      [$clog2(CHUNK_SAMPLES+1)-1:0]     samples,
    output logic      [POS_W-1:0]                       pos_after
);

    localparam int SW = $clog2(CHUNK_SAMPLES + 1);
    localparam logic [POS_W-1:0] LIMIT = POS_W'(2 * CHUNK_SAMPLES);
    localparam logic [SW-1:0]    FULL  = SW'(CHUNK_SAMPLES);

    logic [POS_W-1:0] end_ext;
    logic [POS_W-1:0] rem;
    logic [SW-1:0]    cand;

    assign end_ext = {1'b0, data_end};
    assign rem     = end_ext - pos;

    always_comb
    begin
        if (pos >= end_ext)
            cand = '0;
        else if (rem >= LIMIT)
            cand = FULL;
        else
            cand = rem[SW:1];
        samples = {cand[SW-1:1], 1'b0};
    end

    assign pos_after = pos + POS_W'({samples, 1'b0});

endmodule

`default_nettype wire

### src/adrf_sequencer.sv
`default_nettype none

`include "assert_macros.svh"

module adrf_sequencer
    import adrf_pkg::*;
#(
    parameter int RING_ENTRIES  = RING_ENTRIES_DEF,
    parameter int CHUNK_SAMPLES = CHUNK_SAMPLES_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               mode,
    input  wire logic [POS_W-1:0]   start_address,
    input  wire logic [POS_W-1:0]   end_address,
    input  wire logic               completion_flag,
    input  wire logic               fifo_error_flag,
    input  wire logic               last_valid_done_flag,
    input  wire logic               out_free,
    output logic                    push,
    output result_t                 result
);

    localparam int CW = $clog2(RING_ENTRIES + 1);
    localparam int SW = $clog2(CHUNK_SAMPLES + 1);
    localparam logic [CW-1:0] RING = CW'(RING_ENTRIES);
    localparam wrap_tab_t WRAP = build_wrap(RING_ENTRIES);

    seq_state_t state_reg, state_next;

    logic              mode_reg;
    logic [POS_W-1:0]  start_reg;
    logic [POS_W-1:0]  end_reg;
    logic              comp_reg;
    logic              fifo_reg;
    logic              lvd_reg;

    logic [POS_W-1:0]  next_position_reg, next_position_next;
    logic [ADDR_W-1:0] data_end_reg, data_end_next;
    logic [SLOT_W-1:0] valid_index_reg, valid_index_next;
    logic              stopped_reg, stopped_next;

    logic [ADDR_W-1:0] emit_pos_reg, emit_pos_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     k_reg, k_next;
    result_t           reply_reg, reply_next;

    logic [POS_W-1:0]  unit_pos;
    logic [SW-1:0]     unit_s;
    logic [POS_W-1:0]  unit_sum;
    logic              sel_emit;

    logic [CW+4:0]     cnt_ext;
    logic [SLOT_W-1:0] vi_calc;
    logic [5:0]        wrap_idx;
    logic [SLOT_W-1:0] refill_slot;
    logic              emit_last;

    assign sel_emit = (state_reg == ST_EMIT);
    assign unit_pos = sel_emit ? {1'b0, emit_pos_reg} : next_position_reg;

    adrf_chunk_unit #(
        .CHUNK_SAMPLES (CHUNK_SAMPLES)
    ) u_chunk (
        .pos       (unit_pos),
        .data_end  (data_end_reg),
        .samples   (unit_s),
        .pos_after (unit_sum)
    );

    assign cnt_ext     = (CW+5)'(cnt_reg);
    assign vi_calc     = SLOT_W'(cnt_ext - (CW+5)'(1));
    assign wrap_idx    = {1'b0, valid_index_reg} + 6'd1;
    assign refill_slot = WRAP[wrap_idx];
    assign emit_last   = ((k_reg + CW'(1)) == cnt_reg);

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg  <= mode;
            start_reg <= start_address;
            end_reg   <= end_address;
            comp_reg  <= completion_flag;
            fifo_reg  <= fifo_error_flag;
            lvd_reg   <= last_valid_done_flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            next_position_reg <= '0;
            data_end_reg      <= '0;
            valid_index_reg   <= '0;
            stopped_reg       <= 1'b0;
            cnt_reg           <= '0;
            k_reg             <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            next_position_reg <= next_position_next;
            data_end_reg      <= data_end_next;
            valid_index_reg   <= valid_index_next;
            stopped_reg       <= stopped_next;
            cnt_reg           <= cnt_next;
            k_reg             <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        emit_pos_reg <= emit_pos_next;
        reply_reg    <= reply_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_CLASSIFY;
            end
            ST_CLASSIFY:
            begin
                if (!stopped_reg && !mode_reg && !start_reg[POS_W-1] && !end_reg[POS_W-1])
                    state_next = ST_COUNT;
                else
                    state_next = ST_REPLY;
            end
            ST_COUNT:
            begin
                if (unit_s == '0 || cnt_reg >= RING)
                    state_next = (cnt_reg == '0) ? ST_REPLY : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free && emit_last)
                    state_next = ST_IDLE;
            end
            ST_REPLY:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        push     = ((state_reg == ST_EMIT) || (state_reg == ST_REPLY)) && out_free;
        if (state_reg == ST_EMIT)
        begin
            result.kind  = EV_DESC;
            result.slot  = SLOT_W'(k_reg);
            result.addr  = emit_pos_reg;
            result.count = COUNT_W'(unit_s);
            result.vi    = valid_index_reg;
            result.last  = emit_last;
        end
        else
        begin
            result = reply_reg;
        end
    end

    // Datapath
    always_comb
    begin
        next_position_next = next_position_reg;
        data_end_next      = data_end_reg;
        valid_index_next   = valid_index_reg;
        stopped_next       = stopped_reg;
        emit_pos_next      = emit_pos_reg;
        cnt_next           = cnt_reg;
        k_next             = k_reg;
        reply_next         = reply_reg;

        case (state_reg)
            ST_CLASSIFY:
            begin
                reply_next.slot  = '0;
                reply_next.addr  = '0;
                reply_next.count = '0;
                reply_next.vi    = valid_index_reg;
                reply_next.last  = 1'b1;
                if (stopped_reg)
                    reply_next.kind = EV_STOPPED;
                else if (!mode_reg)
                begin
                    if (start_reg[POS_W-1] || end_reg[POS_W-1])
                        reply_next.kind = EV_ADDR_ERR;
                    else
                    begin
                        reply_next.kind    = EV_NO_DATA;
                        next_position_next = start_reg;
                        data_end_next      = end_reg[ADDR_W-1:0];
                        emit_pos_next      = start_reg[ADDR_W-1:0];
                        cnt_next           = '0;
                    end
                end
                else if (fifo_reg)
                begin
                    reply_next.kind = EV_FIFO_ERR;
                    stopped_next    = 1'b1;
                end
                else if (!comp_reg)
                    reply_next.kind = lvd_reg ? EV_LAST_VALID : EV_SPURIOUS;
                else if (unit_s == '0)
                    reply_next.kind = EV_NO_DATA;
                else
                begin
                    reply_next.kind    = EV_DESC;
                    reply_next.slot    = refill_slot;
                    reply_next.addr    = next_position_reg[ADDR_W-1:0];
                    reply_next.count   = COUNT_W'(unit_s);
                    reply_next.vi      = refill_slot;
                    next_position_next = unit_sum;
                    valid_index_next   = refill_slot;
                end
            end
            ST_COUNT:
            begin
                if (unit_s != '0 && cnt_reg < RING)
                begin
                    next_position_next = unit_sum;
                    cnt_next           = cnt_reg + CW'(1);
                end
                else
                begin
                    valid_index_next = vi_calc;
                    reply_next.vi    = vi_calc;
                    k_next           = '0;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit_pos_next = unit_sum[ADDR_W-1:0];
                    k_next        = k_reg + CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    `ASSERT_IMPLY(a_push_free, clk, rst_n, push, out_free, "push into a full output stage")
    `ASSERT_NEXT(a_stop_sticky, clk, rst_n, stopped_reg, stopped_reg, "stop flag cleared")
    `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_reg <= RING, "descriptor count beyond ring")
    `ASSERT_IMPLY(a_emit_index, clk, rst_n, state_reg == ST_EMIT, k_reg < cnt_reg, "emit index past count")
    `ASSERT_IMPLY(a_emit_nonzero, clk, rst_n, push && sel_emit, unit_s != '0, "empty chunk emitted")

endmodule

`default_nettype wire

### src/audio_descriptor_ring_feeder.sv
// Channel | Handshake            | Payload
// in      | in_valid / in_ready  | mode, start_address, end_address, completion_flag,
//         |                      | fifo_error_flag, last_valid_done_flag
// out     | out_valid / out_ready| event_kind, descriptor_slot, buffer_address,
//         |                      | sample_count, valid_index, last_of_run
//
// One request at a time; in_ready is high only while the sequencer is idle.
// Status request: result held in the reply register, then the output register. Setup:
// a counting and an emit pass on the shared chunk adder, one chunk per cycle if unstalled.
// Output register holds one result; a stalled out_ready stalls the emit pass.
// Reset clears the ring state, stop flag and sequencer; no clearing pass.
`default_nettype none

module audio_descriptor_ring_feeder
    import adrf_pkg::*;
#(
    parameter int RING_ENTRIES  = RING_ENTRIES_DEF,
    parameter int CHUNK_SAMPLES = CHUNK_SAMPLES_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                mode,
    input  wire logic [POS_W-1:0]    start_address,
    input  wire logic [POS_W-1:0]    end_address,
    input  wire logic                completion_flag,
    input  wire logic                fifo_error_flag,
    input  wire logic                last_valid_done_flag,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [KIND_W-1:0]        event_kind,
    output logic [SLOT_W-1:0]        descriptor_slot,
    output logic [ADDR_W-1:0]        buffer_address,
    output logic [COUNT_W-1:0]       sample_count,
    output logic [SLOT_W-1:0]        valid_index,
    output logic                     last_of_run
);

    logic    out_valid_reg, out_valid_next;
    result_t out_reg;
    logic    out_free;
    logic    push;
    result_t result;

    assign out_free = !out_valid_reg || out_ready;

    adrf_sequencer #(
        .RING_ENTRIES  (RING_ENTRIES),
        .CHUNK_SAMPLES (CHUNK_SAMPLES)
    ) u_seq (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .mode                 (mode),
        .start_address        (start_address),
        .end_address          (end_address),
        .completion_flag      (completion_flag),
        .fifo_error_flag      (fifo_error_flag),
        .last_valid_done_flag (last_valid_done_flag),
        .out_free             (out_free),
        .push                 (push),
        .result               (result)
    );

    always_comb
    begin
        if (push)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            out_reg <= result;
    end

    assign out_valid       = out_valid_reg;
    assign event_kind      = out_reg.kind;
    assign descriptor_slot = out_reg.slot;
    assign buffer_address  = out_reg.addr;
    assign sample_count    = out_reg.count;
    assign valid_index     = out_reg.vi;
    assign last_of_run     = out_reg.last;

endmodule

`default_nettype wire
